>>> rtl/mcrmp_pkg.sv
// Shared types, constants and helper functions for the multi-channel range median poller.
// Used by every module under rtl; depends on nothing else.
`default_nettype none

package mcrmp_pkg;

   // Default number of channel entries in the state memory.
   localparam int unsigned CHANNELS_DEFAULT = 3;

   // The connected mask covers this many channels; higher indexes are never connected.
   localparam int unsigned CONN_CHANNELS = 3;

   localparam logic [15:0] DIST_RESET      = 16'd9999;
   localparam logic [2:0]  MASK_RESET      = 3'd7;
   localparam logic [15:0] MAX_LONG_RESET  = 16'd1250;
   localparam logic [15:0] MAX_SIDE_RESET  = 16'd1200;
   localparam logic [7:0]  WAIT_LONG_RESET = 8'd38;
   localparam logic [7:0]  WAIT_SIDE_RESET = 8'd25;
   localparam logic [2:0]  STATUS_MASK     = 3'b111;

   localparam int unsigned CSR_INDEX_W = 3;
   localparam int unsigned CSR_DATA_W  = 16;

   localparam logic [CSR_INDEX_W-1:0] CSR_CONNECTED_MASK = 3'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_MAX_RANGE_LONG = 3'd1;
   localparam logic [CSR_INDEX_W-1:0] CSR_MAX_RANGE_SIDE = 3'd2;
   localparam logic [CSR_INDEX_W-1:0] CSR_WAIT_LONG_MS   = 3'd3;
   localparam logic [CSR_INDEX_W-1:0] CSR_WAIT_SIDE_MS   = 3'd4;

   localparam logic       FUNC_START = 1'b0;
   localparam logic       FUNC_POLL  = 1'b1;
   localparam logic [1:0] LONG_CHANNEL = 2'd0;
   localparam logic [1:0] LAST_SLOT    = 2'd2;

   // One channel's state, held as one memory word.
   typedef struct packed {
      logic             armed;
      logic [31:0]      stamp;
      logic [2:0][15:0] window;
      logic [1:0]       slot;
      logic [15:0]      filtered;
   } entry_type;

   localparam entry_type ENTRY_RESET = '{
      armed:    1'b0,
      stamp:    32'd0,
      window:   48'd0,
      slot:     2'd0,
      filtered: DIST_RESET
   };

   typedef struct packed {
      logic [2:0]  connected_mask;
      logic [15:0] max_range_long;
      logic [15:0] max_range_side;
      logic [7:0]  wait_long_ms;
      logic [7:0]  wait_side_ms;
   } cfg_type;

   typedef struct packed {
      logic start_ranging;
      logic clear_interrupt;
      logic sample_taken;
   } flags_type;

   // Median of three unsigned values, built from three parallel compares.
   function automatic logic [15:0] med3(input logic [15:0] a, input logic [15:0] b,
                                        input logic [15:0] c);
      logic ab;
      logic bc;
      logic ac;
      ab = (a > b);
      bc = (b > c);
      ac = (a > c);
      if (ab == bc) begin
         return b;
      end else if (ab == ac) begin
         return c;
      end else begin
         return a;
      end
   endfunction

endpackage

`default_nettype wire

>>> rtl/multi_channel_range_median_poller_core.sv
// Top level of the multi-channel range median poller: config registers, pipeline and result beat.
// Depends on mcrmp_pkg, mcrmp_entry_mem and mcrmp_update.
//
// The block accepts one request beat per clock cycle while req_stall is low and returns exactly
// one response beat for each, in order, after it has passed through the update stage and the
// response register. The rate is set by the channel state memory: each beat reads its channel's
// entry at the accepting edge, and the entry is updated and written back as the beat leaves the
// update stage for the response register. A beat that reads the entry being written in the same
// cycle gets the new value through forwarding, so back-to-back beats on one channel see each
// other's updates. Response stalls back up into the update stage and then into req_stall; one
// beat can still be taken while a finished response waits. Channel entries start at the reset
// state through per-entry valid bits, so no clearing pass is needed after reset. Configuration
// registers are written through csr_wr_en, csr_index and csr_wdata and must only be changed
// while no beat is in flight.
`default_nettype none

module multi_channel_range_median_poller_core
   import mcrmp_pkg::*;
#(
   parameter int unsigned CHANNELS = CHANNELS_DEFAULT
) (
   input  wire logic                   clock,
   input  wire logic                   reset,

   input  wire logic                   req_valid,
   output logic                        req_stall,
   input  wire logic                   req_func,
   input  wire logic [1:0]             req_channel,
   input  wire logic [31:0]            req_now_ms,
   input  wire logic [7:0]             req_irq_status,
   input  wire logic [15:0]            req_raw_range,

   output logic                        rsp_valid,
   input  wire logic                   rsp_stall,
   output logic                        rsp_start_ranging,
   output logic                        rsp_clear_interrupt,
   output logic                        rsp_sample_taken,
   output logic [15:0]                 rsp_distance,

   input  wire logic                   csr_wr_en,
   input  wire logic [CSR_INDEX_W-1:0] csr_index,
   input  wire logic [CSR_DATA_W-1:0]  csr_wdata
);

   localparam int unsigned ADDR_W = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;

   // Configuration registers.
   cfg_type cfg_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.connected_mask <= MASK_RESET;
         cfg_ff.max_range_long <= MAX_LONG_RESET;
         cfg_ff.max_range_side <= MAX_SIDE_RESET;
         cfg_ff.wait_long_ms   <= WAIT_LONG_RESET;
         cfg_ff.wait_side_ms   <= WAIT_SIDE_RESET;
      end else if (csr_wr_en) begin
         unique case (csr_index)
            CSR_CONNECTED_MASK: cfg_ff.connected_mask <= csr_wdata[2:0];
            CSR_MAX_RANGE_LONG: cfg_ff.max_range_long <= csr_wdata[15:0];
            CSR_MAX_RANGE_SIDE: cfg_ff.max_range_side <= csr_wdata[15:0];
            CSR_WAIT_LONG_MS:   cfg_ff.wait_long_ms   <= csr_wdata[7:0];
            CSR_WAIT_SIDE_MS:   cfg_ff.wait_side_ms   <= csr_wdata[7:0];
            default: begin
            end
         endcase
      end
   end

   // Update stage holding the accepted beat while its memory read completes.
   logic              s1_valid_ff;
   logic              s1_func_ff;
   logic [1:0]        s1_channel_ff;
   logic              s1_in_range_ff;
   logic [ADDR_W-1:0] s1_addr_ff;
   logic [31:0]       s1_now_ms_ff;
   logic [7:0]        s1_irq_status_ff;
   logic [15:0]       s1_raw_range_ff;

   logic              rsp_valid_ff;
   flags_type         rsp_flags_ff;
   logic [15:0]       rsp_distance_ff;

   logic              accept;
   logic              s1_move;
   logic              req_in_range;
   logic [ADDR_W-1:0] req_addr;

   entry_type         rd_entry;
   entry_type         upd_entry;
   logic              upd_write;
   flags_type         upd_flags;
   logic [15:0]       upd_distance;
   logic              wr_en;

   assign s1_move   = s1_valid_ff && (!rsp_valid_ff || !rsp_stall);
   assign req_stall = s1_valid_ff && !s1_move;
   assign accept    = req_valid && !req_stall;

   // Channels beyond the memory read entry zero; their result ignores the data.
   assign req_in_range = (32'(req_channel) < CHANNELS);
   assign req_addr     = req_in_range ? ADDR_W'(req_channel) : '0;

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
      end else if (accept) begin
         s1_valid_ff <= 1'b1;
      end else if (s1_move) begin
         s1_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         s1_func_ff       <= req_func;
         s1_channel_ff    <= req_channel;
         s1_in_range_ff   <= req_in_range;
         s1_addr_ff       <= req_addr;
         s1_now_ms_ff     <= req_now_ms;
         s1_irq_status_ff <= req_irq_status;
         s1_raw_range_ff  <= req_raw_range;
      end
   end

   mcrmp_entry_mem #(
      .DEPTH  (CHANNELS),
      .ADDR_W (ADDR_W)
   ) u_entry_mem (
      .clock   (clock),
      .reset   (reset),
      .rd_en   (accept),
      .rd_addr (req_addr),
      .rd_data (rd_entry),
      .wr_en   (wr_en),
      .wr_addr (s1_addr_ff),
      .wr_data (upd_entry)
   );

   mcrmp_update u_update (
      .func       (s1_func_ff),
      .channel    (s1_channel_ff),
      .in_range   (s1_in_range_ff),
      .now_ms     (s1_now_ms_ff),
      .irq_status (s1_irq_status_ff),
      .raw_range  (s1_raw_range_ff),
      .cfg        (cfg_ff),
      .old_entry  (rd_entry),
      .new_entry  (upd_entry),
      .write      (upd_write),
      .flags      (upd_flags),
      .distance   (upd_distance)
   );

   // The entry is written back only when the beat leaves the update stage and the update calls for a write.
   assign wr_en = s1_move && upd_write;

   // Response register.
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (s1_move) begin
         rsp_valid_ff <= 1'b1;
      end else if (!rsp_stall) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (s1_move) begin
         rsp_flags_ff    <= upd_flags;
         rsp_distance_ff <= upd_distance;
      end
   end

   assign rsp_valid           = rsp_valid_ff;
   assign rsp_start_ranging   = rsp_flags_ff.start_ranging;
   assign rsp_clear_interrupt = rsp_flags_ff.clear_interrupt;
   assign rsp_sample_taken    = rsp_flags_ff.sample_taken;
   assign rsp_distance        = rsp_distance_ff;

   // A taken sample always clears the interrupt and re-arms the channel.
   a_sample_flags: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && rsp_flags_ff.sample_taken |->
         rsp_flags_ff.start_ranging && rsp_flags_ff.clear_interrupt)
      else $error("sample taken without start and clear");

   // The state memory is written only by a beat leaving the update stage.
   a_write_on_move: assert property (@(posedge clock) disable iff (reset)
      wr_en |-> s1_valid_ff && (!rsp_valid_ff || !rsp_stall))
      else $error("entry write without a moving beat");

   // A channel beyond the memory never changes state and reports the reset distance.
   a_out_of_range: assert property (@(posedge clock) disable iff (reset)
      s1_move && !s1_in_range_ff |-> !wr_en ##1
         (rsp_distance_ff == DIST_RESET) && !rsp_flags_ff.start_ranging)
      else $error("out-of-range channel produced a result");

   // The request side is held back only while the update stage is full and blocked.
   a_stall_cause: assert property (@(posedge clock) disable iff (reset)
      req_stall |-> s1_valid_ff && rsp_valid_ff && rsp_stall)
      else $error("request stalled without a blocked response");

endmodule

`default_nettype wire

>>> rtl/mcrmp_entry_mem.sv
// Per-channel state memory with registered synchronous read, valid bits and write forwarding.
// Depends on mcrmp_pkg for the entry type and its reset value.
`default_nettype none

module mcrmp_entry_mem
   import mcrmp_pkg::*;
#(
   parameter int unsigned DEPTH  = CHANNELS_DEFAULT,
   parameter int unsigned ADDR_W = 2
) (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              rd_en,
   input  wire logic [ADDR_W-1:0] rd_addr,
   output entry_type              rd_data,
   input  wire logic              wr_en,
   input  wire logic [ADDR_W-1:0] wr_addr,
   input  wire entry_type         wr_data
);

   entry_type             mem [DEPTH];
   entry_type             mem_q_ff;
   entry_type             byp_ff;
   logic                  hit_ff;
   logic                  vld_ff;
   logic [DEPTH-1:0]      valid_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         mem_q_ff <= mem[rd_addr];
         byp_ff   <= wr_data;
         hit_ff   <= wr_en && (wr_addr == rd_addr);
         vld_ff   <= valid_ff[rd_addr];
      end
   end

   // An entry that was never written reads as the reset state.
   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else if (wr_en) begin
         valid_ff[wr_addr] <= 1'b1;
      end
   end

   always_comb begin
      if (hit_ff) begin
         rd_data = byp_ff;
      end else if (vld_ff) begin
         rd_data = mem_q_ff;
      end else begin
         rd_data = ENTRY_RESET;
      end
   end

endmodule

`default_nettype wire

>>> rtl/mcrmp_update.sv
// Combinational update of one channel entry for a start or poll beat: clamp, ring write, median.
// Depends on mcrmp_pkg for the entry, config and flag types and the median function.
`default_nettype none

module mcrmp_update
   import mcrmp_pkg::*;
(
   input  wire logic        func,
   input  wire logic [1:0]  channel,
   input  wire logic        in_range,
   input  wire logic [31:0] now_ms,
   input  wire logic [7:0]  irq_status,
   input  wire logic [15:0] raw_range,
   input  wire cfg_type     cfg,
   input  wire entry_type   old_entry,
   output entry_type        new_entry,
   output logic             write,
   output flags_type        flags,
   output logic [15:0]      distance
);

   logic             connected;
   logic             is_long;
   logic [7:0]       wait_ms;
   logic [15:0]      limit;
   logic [31:0]      elapsed;
   logic             wait_done;
   logic             ready;
   logic [15:0]      clamped;
   logic [1:0]       slot;
   logic [2:0][15:0] win;
   logic             do_start;

   always_comb begin
      connected = (32'(channel) < CONN_CHANNELS) && cfg.connected_mask[channel];
      is_long   = (channel == LONG_CHANNEL);
      wait_ms   = is_long ? cfg.wait_long_ms : cfg.wait_side_ms;
      limit     = is_long ? cfg.max_range_long : cfg.max_range_side;
      elapsed   = now_ms - old_entry.stamp;
      wait_done = (elapsed[31:8] != 24'd0) || (elapsed[7:0] >= wait_ms);
      ready     = in_range && (func == FUNC_POLL) && connected && old_entry.armed &&
                  wait_done && ((irq_status[2:0] & STATUS_MASK) != 3'd0);
      do_start  = in_range && (func == FUNC_START) && connected;
      clamped   = (raw_range < limit) ? raw_range : limit;
      slot      = (old_entry.slot > LAST_SLOT) ? 2'd0 : old_entry.slot;

      for (int i = 0; i < 3; i++) begin
         win[i] = (slot == 2'(i)) ? clamped : old_entry.window[i];
      end

      new_entry = old_entry;
      if (do_start) begin
         new_entry.armed = 1'b1;
         new_entry.stamp = now_ms;
      end else if (ready) begin
         new_entry.armed    = 1'b1;
         new_entry.stamp    = now_ms;
         new_entry.window   = win;
         new_entry.slot     = (slot == LAST_SLOT) ? 2'd0 : slot + 2'd1;
         new_entry.filtered = med3(win[0], win[1], win[2]);
      end

      write                 = do_start || ready;
      flags.start_ranging   = do_start || ready;
      flags.clear_interrupt = ready;
      flags.sample_taken    = ready;
      distance              = in_range ? new_entry.filtered : DIST_RESET;
   end

endmodule

`default_nettype wire
